FILE: rtl/crt_general_merge_top_assert.svh
// Assertion macros for the CRT merge block.
`ifndef CRT_GENERAL_MERGE_TOP_ASSERT_SVH
`define CRT_GENERAL_MERGE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define CGM_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("cgm assertion failed");
`define CGM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cgm assertion failed");
`else
`define CGM_ASSERT(label, clk, rst, expr)
`define CGM_ASSERT_IMP(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/cgm_pkg.sv
// Shared constants, command and status types for the CRT merge block.
package cgm_pkg;

   localparam int IN_W   = 32;
   localparam int MOD_W  = 64;
   localparam int COEF_W = IN_W + 2;
   localparam int DCNT_W = $clog2(MOD_W);
   localparam int MCNT_W = $clog2(IN_W);

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOSOL = 2'd1;
   localparam logic [1:0] ST_OVF   = 2'd2;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_RED, OP_GCD_INIT, OP_GCD, OP_AMOD, OP_DQ, OP_M1,
      OP_N2, OP_LCM, OP_INV, OP_EU_DIV, OP_EU_MUL, OP_K_MUL, OP_K_MOD,
      OP_ACC, OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   go;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic y_zero;
      logic r1_zero;
      logic fail_nz;
      logic out_free;
   } stat_type;

   function automatic logic is_mul_op(op_type op);
      logic res;
      case (op)
         OP_LCM, OP_EU_MUL, OP_K_MUL, OP_ACC: res = 1'b1;
         default: res = 1'b0;
      endcase
      return res;
   endfunction

endpackage

FILE: rtl/cgm_dpath.sv
// Datapath: accumulators, work registers, serial divider and multiplier.
`include "crt_general_merge_top_assert.svh"
module cgm_dpath import cgm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output stat_type         stat,
   input  logic             req_start_req,
   input  logic [IN_W-1:0]  req_residue,
   input  logic [IN_W-1:0]  req_modulus,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [MOD_W-1:0] rsp_combined_residue,
   output logic [MOD_W-1:0] rsp_combined_modulus,
   output logic [1:0]       rsp_status
);

   localparam int P_W = MOD_W + IN_W;

   logic [MOD_W-1:0]  ar_ff, am_ff, x_ff, y_ff, m1_ff, lcm_ff, kp_ff;
   logic [1:0]        fail_ff;
   logic [IN_W-1:0]   n_ff, r_ff, d_ff, t_ff, n2_ff, r0_ff, r1_ff, q_ff, s_ff, k_ff;
   logic [COEF_W-1:0] t0_ff, t1_ff;

   logic              rsp_valid_ff;
   logic [MOD_W-1:0]  rsp_res_ff, rsp_mod_ff;
   logic [1:0]        rsp_st_ff;

   // divider
   logic [MOD_W-1:0]  quo_ff, rem_ff, den_ff, dv_num, dv_den;
   logic [DCNT_W-1:0] dcnt_ff;
   logic              dbusy_ff, ddone_ff, div_go;
   logic [MOD_W:0]    rem_sh;
   logic [MOD_W+1:0]  rem_diff;
   logic              rem_ge;

   // multiplier
   logic [P_W-1:0]    mp_ff;
   logic [MOD_W-1:0]  ma_ff, mu_a;
   logic [IN_W-1:0]   mu_b;
   logic [MCNT_W-1:0] mcnt_ff;
   logic              mbusy_ff, mdone_ff, mul_go;
   logic [MOD_W:0]    mp_sum;

   logic              do_emit;
   logic [IN_W-1:0]   g, amn, inv;
   logic [COEF_W-1:0] t1_mag, tn, prod_lo;

   assign g        = x_ff[IN_W-1:0];
   assign amn      = rem_ff[IN_W-1:0];
   assign t1_mag   = t1_ff[COEF_W-1] ? (~t1_ff + COEF_W'(1)) : t1_ff;
   assign prod_lo  = mp_ff[COEF_W-1:0];
   assign tn       = t1_ff[COEF_W-1] ? (t0_ff + prod_lo) : (t0_ff - prod_lo);
   assign inv      = t0_ff[COEF_W-1] ? IN_W'(t0_ff + COEF_W'(n2_ff)) : IN_W'(t0_ff);
   assign mul_go   = cmd.go && is_mul_op(cmd.op);
   assign div_go   = cmd.go && !is_mul_op(cmd.op);
   assign do_emit  = (cmd.op == OP_EMIT) && stat.out_free;

   always_comb begin
      dv_num = x_ff;
      dv_den = y_ff;
      case (cmd.op)
         OP_RED: begin
            dv_num = MOD_W'(r_ff);
            dv_den = MOD_W'(n_ff);
         end
         OP_AMOD: begin
            dv_num = ar_ff;
            dv_den = MOD_W'(n_ff);
         end
         OP_DQ: begin
            dv_num = MOD_W'(d_ff);
            dv_den = MOD_W'(g);
         end
         OP_M1: begin
            dv_num = am_ff;
            dv_den = MOD_W'(g);
         end
         OP_N2: begin
            dv_num = MOD_W'(n_ff);
            dv_den = MOD_W'(g);
         end
         OP_INV: begin
            dv_num = m1_ff;
            dv_den = MOD_W'(n2_ff);
         end
         OP_EU_DIV: begin
            dv_num = MOD_W'(r0_ff);
            dv_den = MOD_W'(r1_ff);
         end
         OP_K_MOD: begin
            dv_num = kp_ff;
            dv_den = MOD_W'(n2_ff);
         end
         default: begin
            dv_num = x_ff;
            dv_den = y_ff;
         end
      endcase
   end

   always_comb begin
      mu_a = am_ff;
      mu_b = k_ff;
      case (cmd.op)
         OP_LCM: begin
            mu_a = m1_ff;
            mu_b = n_ff;
         end
         OP_EU_MUL: begin
            mu_a = MOD_W'(t1_mag);
            mu_b = q_ff;
         end
         OP_K_MUL: begin
            mu_a = MOD_W'(t_ff);
            mu_b = inv;
         end
         default: begin
            mu_a = am_ff;
            mu_b = k_ff;
         end
      endcase
   end

   // restoring division, one quotient bit per cycle
   assign rem_sh   = {rem_ff, quo_ff[MOD_W-1]};
   assign rem_diff = {1'b0, rem_sh} - {2'b00, den_ff};
   assign rem_ge   = !rem_diff[MOD_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
         ddone_ff <= 1'b0;
         dcnt_ff  <= '0;
      end else begin
         ddone_ff <= 1'b0;
         if (div_go) begin
            quo_ff   <= dv_num;
            rem_ff   <= '0;
            den_ff   <= dv_den;
            dcnt_ff  <= DCNT_W'(MOD_W - 1);
            dbusy_ff <= 1'b1;
         end else if (dbusy_ff) begin
            quo_ff <= {quo_ff[MOD_W-2:0], rem_ge};
            rem_ff <= rem_ge ? rem_diff[MOD_W-1:0] : rem_sh[MOD_W-1:0];
            if (dcnt_ff == '0) begin
               dbusy_ff <= 1'b0;
               ddone_ff <= 1'b1;
            end else begin
               dcnt_ff <= dcnt_ff - DCNT_W'(1);
            end
         end
      end
   end

   // shift-add multiply, one multiplier bit per cycle
   assign mp_sum = {1'b0, mp_ff[P_W-1:IN_W]} + {1'b0, ma_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff <= 1'b0;
         mdone_ff <= 1'b0;
         mcnt_ff  <= '0;
      end else begin
         mdone_ff <= 1'b0;
         if (mul_go) begin
            mp_ff    <= {{MOD_W{1'b0}}, mu_b};
            ma_ff    <= mu_a;
            mcnt_ff  <= MCNT_W'(IN_W - 1);
            mbusy_ff <= 1'b1;
         end else if (mbusy_ff) begin
            mp_ff <= mp_ff[0] ? {mp_sum, mp_ff[IN_W-1:1]} : {1'b0, mp_ff[P_W-1:1]};
            if (mcnt_ff == '0) begin
               mbusy_ff <= 1'b0;
               mdone_ff <= 1'b1;
            end else begin
               mcnt_ff <= mcnt_ff - MCNT_W'(1);
            end
         end
      end
   end

   // accumulators and work registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ar_ff   <= '0;
         am_ff   <= MOD_W'(1);
         fail_ff <= ST_OK;
      end else begin
         if (cmd.op == OP_LOAD) begin
            if (req_start_req) begin
               ar_ff   <= '0;
               am_ff   <= MOD_W'(1);
               fail_ff <= ST_OK;
            end
            n_ff <= (req_modulus == '0) ? IN_W'(1) : req_modulus;
            r_ff <= req_residue;
         end
         if (cmd.op == OP_GCD_INIT) begin
            x_ff <= am_ff;
            y_ff <= MOD_W'(n_ff);
         end
         if (ddone_ff) begin
            case (cmd.op)
               OP_RED: r_ff <= rem_ff[IN_W-1:0];
               OP_GCD: begin
                  x_ff <= y_ff;
                  y_ff <= rem_ff;
               end
               OP_AMOD: d_ff <= (r_ff >= amn) ? (r_ff - amn) : (r_ff + (n_ff - amn));
               OP_DQ: begin
                  t_ff <= quo_ff[IN_W-1:0];
                  if (rem_ff != '0) fail_ff <= ST_NOSOL;
               end
               OP_M1: m1_ff <= quo_ff;
               OP_N2: n2_ff <= quo_ff[IN_W-1:0];
               OP_INV: begin
                  r1_ff <= rem_ff[IN_W-1:0];
                  r0_ff <= n2_ff;
                  t0_ff <= '0;
                  t1_ff <= COEF_W'(1);
               end
               OP_EU_DIV: begin
                  q_ff <= quo_ff[IN_W-1:0];
                  s_ff <= rem_ff[IN_W-1:0];
               end
               OP_K_MOD: k_ff <= rem_ff[IN_W-1:0];
               default: ;
            endcase
         end
         if (mdone_ff) begin
            case (cmd.op)
               OP_LCM: begin
                  if (mp_ff[P_W-1:MOD_W] != '0) fail_ff <= ST_OVF;
                  else lcm_ff <= mp_ff[MOD_W-1:0];
               end
               OP_EU_MUL: begin
                  r0_ff <= r1_ff;
                  r1_ff <= s_ff;
                  t0_ff <= t1_ff;
                  t1_ff <= tn;
               end
               OP_K_MUL: kp_ff <= mp_ff[MOD_W-1:0];
               OP_ACC: begin
                  ar_ff <= ar_ff + mp_ff[MOD_W-1:0];
                  am_ff <= lcm_ff;
               end
               default: ;
            endcase
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (do_emit) begin
         rsp_valid_ff <= 1'b1;
         rsp_res_ff   <= (fail_ff == ST_OK) ? ar_ff : '0;
         rsp_mod_ff   <= am_ff;
         rsp_st_ff    <= fail_ff;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign stat.done     = ddone_ff | mdone_ff;
   assign stat.y_zero   = (y_ff == '0);
   assign stat.r1_zero  = (r1_ff == '0);
   assign stat.fail_nz  = (fail_ff != ST_OK);
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_combined_residue = rsp_res_ff;
   assign rsp_combined_modulus = rsp_mod_ff;
   assign rsp_status           = rsp_st_ff;

   `CGM_ASSERT(a_units_excl, clock, reset, !(dbusy_ff && mbusy_ff))
   `CGM_ASSERT_IMP(a_go_idle, clock, reset, cmd.go, !dbusy_ff && !mbusy_ff)
   `CGM_ASSERT_IMP(a_ok_reduced, clock, reset, rsp_valid_ff && rsp_st_ff == ST_OK, rsp_res_ff < rsp_mod_ff)
   `CGM_ASSERT_IMP(a_fail_zero, clock, reset, rsp_valid_ff && rsp_st_ff != ST_OK, rsp_res_ff == '0)

endmodule

FILE: rtl/cgm_ctrl.sv
// Controller: sequences the merge steps over the datapath units.
module cgm_ctrl import cgm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_RED, S_RED_W, S_CHK, S_GCD_C, S_GCD_W, S_AMOD, S_AMOD_W,
      S_DQ, S_DQ_W, S_DQ_C, S_M1, S_M1_W, S_N2, S_N2_W, S_LCM, S_LCM_W,
      S_LCM_C, S_INV, S_INV_W, S_EU_C, S_EU_DW, S_EU_M, S_EU_MW, S_KM,
      S_KM_W, S_KD, S_KD_W, S_AC, S_AC_W, S_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      cmd.go   = 1'b0;
      case (state_ff)
         S_IDLE: if (req_valid) begin
            cmd.op   = OP_LOAD;
            state_in = S_RED;
         end
         S_RED: begin
            cmd.op = OP_RED; cmd.go = 1'b1; state_in = S_RED_W;
         end
         S_RED_W: begin
            cmd.op = OP_RED;
            if (stat.done) state_in = S_CHK;
         end
         S_CHK: begin
            if (stat.fail_nz) state_in = S_EMIT;
            else begin
               cmd.op = OP_GCD_INIT; state_in = S_GCD_C;
            end
         end
         S_GCD_C: begin
            if (stat.y_zero) state_in = S_AMOD;
            else begin
               cmd.op = OP_GCD; cmd.go = 1'b1; state_in = S_GCD_W;
            end
         end
         S_GCD_W: begin
            cmd.op = OP_GCD;
            if (stat.done) state_in = S_GCD_C;
         end
         S_AMOD: begin
            cmd.op = OP_AMOD; cmd.go = 1'b1; state_in = S_AMOD_W;
         end
         S_AMOD_W: begin
            cmd.op = OP_AMOD;
            if (stat.done) state_in = S_DQ;
         end
         S_DQ: begin
            cmd.op = OP_DQ; cmd.go = 1'b1; state_in = S_DQ_W;
         end
         S_DQ_W: begin
            cmd.op = OP_DQ;
            if (stat.done) state_in = S_DQ_C;
         end
         S_DQ_C: state_in = stat.fail_nz ? S_EMIT : S_M1;
         S_M1: begin
            cmd.op = OP_M1; cmd.go = 1'b1; state_in = S_M1_W;
         end
         S_M1_W: begin
            cmd.op = OP_M1;
            if (stat.done) state_in = S_N2;
         end
         S_N2: begin
            cmd.op = OP_N2; cmd.go = 1'b1; state_in = S_N2_W;
         end
         S_N2_W: begin
            cmd.op = OP_N2;
            if (stat.done) state_in = S_LCM;
         end
         S_LCM: begin
            cmd.op = OP_LCM; cmd.go = 1'b1; state_in = S_LCM_W;
         end
         S_LCM_W: begin
            cmd.op = OP_LCM;
            if (stat.done) state_in = S_LCM_C;
         end
         S_LCM_C: state_in = stat.fail_nz ? S_EMIT : S_INV;
         S_INV: begin
            cmd.op = OP_INV; cmd.go = 1'b1; state_in = S_INV_W;
         end
         S_INV_W: begin
            cmd.op = OP_INV;
            if (stat.done) state_in = S_EU_C;
         end
         S_EU_C: begin
            if (stat.r1_zero) state_in = S_KM;
            else begin
               cmd.op = OP_EU_DIV; cmd.go = 1'b1; state_in = S_EU_DW;
            end
         end
         S_EU_DW: begin
            cmd.op = OP_EU_DIV;
            if (stat.done) state_in = S_EU_M;
         end
         S_EU_M: begin
            cmd.op = OP_EU_MUL; cmd.go = 1'b1; state_in = S_EU_MW;
         end
         S_EU_MW: begin
            cmd.op = OP_EU_MUL;
            if (stat.done) state_in = S_EU_C;
         end
         S_KM: begin
            cmd.op = OP_K_MUL; cmd.go = 1'b1; state_in = S_KM_W;
         end
         S_KM_W: begin
            cmd.op = OP_K_MUL;
            if (stat.done) state_in = S_KD;
         end
         S_KD: begin
            cmd.op = OP_K_MOD; cmd.go = 1'b1; state_in = S_KD_W;
         end
         S_KD_W: begin
            cmd.op = OP_K_MOD;
            if (stat.done) state_in = S_AC;
         end
         S_AC: begin
            cmd.op = OP_ACC; cmd.go = 1'b1; state_in = S_AC_W;
         end
         S_AC_W: begin
            cmd.op = OP_ACC;
            if (stat.done) state_in = S_EMIT;
         end
         S_EMIT: begin
            cmd.op = OP_EMIT;
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

FILE: rtl/crt_general_merge_top.sv
// Top level of the generalized CRT merge block.
//
//   channel | ports                                                   | direction
//   --------+---------------------------------------------------------+----------
//   req     | req_valid/ready, req_start_req, req_residue, req_modulus | in
//   rsp     | rsp_valid/ready, rsp_combined_residue/_modulus, rsp_status | out
//
// One transaction is merged at a time. A merge runs a restoring divider
// and a shift-add multiplier, one pass per operation:
// 7 divisions + 3 multiplies, plus one division per gcd step and one division
// and one multiply per inverse step.
// An item held by a sticky failure runs the reduction only.
// Reset is synchronous: system back to 0 mod 1, status ok, result register empty.
// The result register frees the unit: a new transaction is taken while a
// result waits; a stalled rsp side only holds the next result at its final step.
module crt_general_merge_top import cgm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_start_req,
   input  logic [IN_W-1:0]  req_residue,
   input  logic [IN_W-1:0]  req_modulus,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [MOD_W-1:0] rsp_combined_residue,
   output logic [MOD_W-1:0] rsp_combined_modulus,
   output logic [1:0]       rsp_status
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer: start and wait states for each step of the merge, plus check states
   cgm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // accumulators, shared divider and multiplier, result register
   cgm_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_start_req        (req_start_req),
      .req_residue          (req_residue),
      .req_modulus          (req_modulus),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_combined_residue (rsp_combined_residue),
      .rsp_combined_modulus (rsp_combined_modulus),
      .rsp_status           (rsp_status)
   );

endmodule

FILE: bench/crt_general_merge_top_tb.sv
// Self-checking bench for the generalized CRT merge block: directed and random congruences.
module crt_general_merge_top_tb;
   import cgm_pkg::*;

   localparam int HOLD_CYCLES  = 3000;    // long rsp stall to back up the block
   localparam int WATCH_LIMIT  = 60000;   // cycles without any transaction
   localparam int DRAIN_CYCLES = 6000;    // a worst-case merge plus margin
   localparam int QUIET_LO     = 40000;   // window with no random idling
   localparam int QUIET_HI     = 120000;

   typedef struct packed {
      logic            start;
      logic [IN_W-1:0] residue;
      logic [IN_W-1:0] modulus;
   } congruence_type;

   typedef struct packed {
      logic [MOD_W-1:0] residue;
      logic [MOD_W-1:0] modulus;
      logic [1:0]       status;
   } solution_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_start_req = 1'b0;
   logic [IN_W-1:0]  req_residue = '0;
   logic [IN_W-1:0]  req_modulus = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [MOD_W-1:0] rsp_combined_residue;
   logic [MOD_W-1:0] rsp_combined_modulus;
   logic [1:0]       rsp_status;

   congruence_type pending_q[$];
   solution_type   solution_q[$];
   int          mismatches = 0;
   int          cycle_cnt  = 0;
   int          quiet_cnt  = 0;
   logic        req_fired  = 1'b0;
   logic        hold_done  = 1'b0;
   int          hold_left  = 0;

   // predictor copy of the combined system
   logic [MOD_W-1:0] sys_residue = '0;
   logic [MOD_W-1:0] sys_modulus = 64'd1;
   logic [1:0]       sys_status  = ST_OK;

   crt_general_merge_top u_dut (.*);

   always #2 clock = ~clock;

   function automatic logic [63:0] gcd64(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   // inverse of a mod m by extended Euclid; 0 for m of one or no inverse
   function automatic logic [63:0] inverse64(input logic [63:0] a, input logic [63:0] m);
      logic signed [129:0] r0, r1, t0, t1, q, tmp;
      if (m == 1) return 64'd0;
      r0 = $signed({66'd0, m});
      r1 = $signed({66'd0, a % m});
      t0 = 0;
      t1 = 1;
      while (r1 != 0) begin
         q = r0 / r1;
         tmp = r0 - q * r1; r0 = r1; r1 = tmp;
         tmp = t0 - q * t1; t0 = t1; t1 = tmp;
      end
      if (r0 != 1) return 64'd0;
      t0 = t0 % $signed({66'd0, m});
      if (t0 < 0) t0 = t0 + $signed({66'd0, m});
      return t0[63:0];
   endfunction

   function automatic solution_type merge_congruence(input congruence_type c);
      logic [63:0]  n, r, g, m1, n2, t, inv, rg, ag;
      logic [127:0] k;
      solution_type s;
      if (c.start) begin
         sys_residue = '0;
         sys_modulus = 64'd1;
         sys_status  = ST_OK;
      end
      n = (c.modulus == 0) ? 64'd1 : {32'd0, c.modulus};
      r = {32'd0, c.residue} % n;
      if (sys_status == ST_OK) begin
         g = gcd64(sys_modulus, n);
         if (r % g != sys_residue % g) sys_status = ST_NOSOL;
         else begin
            m1 = sys_modulus / g;
            n2 = n / g;
            if (m1 > {64{1'b1}} / n) sys_status = ST_OVF;
            else begin
               rg = (r / g) % n2;
               ag = (sys_residue / g) % n2;
               t = (rg >= ag) ? rg - ag : rg + (n2 - ag);
               inv = inverse64(m1 % n2, n2);
               k = ({64'd0, t} * {64'd0, inv}) % {64'd0, n2};
               sys_residue = sys_residue + k[63:0] * sys_modulus;
               sys_modulus = m1 * n;
            end
         end
      end
      s.residue = (sys_status == ST_OK) ? sys_residue : '0;
      s.modulus = sys_modulus;
      s.status  = sys_status;
      return s;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      mismatches++;
   endtask

   task automatic add_item(input logic s, input logic [31:0] r, input logic [31:0] m);
      congruence_type c;
      c.start = s; c.residue = r; c.modulus = m;
      pending_q.push_back(c);
   endtask

   function automatic logic [31:0] pick_modulus();
      case ($urandom_range(0, 5))
         0: return $urandom_range(1, 16);
         1, 2: return $urandom_range(2, 1000);
         3: return $urandom_range(1000, 1 << 20);
         4: return $urandom;
         default: return 32'hFFFF_FFFF - $urandom_range(0, 7);
      endcase
   endfunction

   // Driver: advances the request channel on the falling edge.
   always @(negedge clock) begin
      congruence_type c;
      if (!reset && (!req_valid || req_fired)) begin
         if (pending_q.size() != 0 &&
             (cycle_cnt inside {[QUIET_LO:QUIET_HI]} || $urandom_range(0, 99) >= 10)) begin
            c = pending_q.pop_front();
            req_valid     <= 1'b1;
            req_start_req <= c.start;
            req_residue   <= c.residue;
            req_modulus   <= c.modulus;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold once the run is well under way.
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && cycle_cnt == 20000) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= cycle_cnt inside {[QUIET_LO:QUIET_HI]} || $urandom_range(0, 99) >= 10;
      end
   end

   // Monitor: predicts on accepted requests, checks accepted results.
   always @(posedge clock) begin
      solution_type want;
      cycle_cnt <= cycle_cnt + 1;
      req_fired <= req_valid && req_ready && !reset;
      if (!reset) begin
         if (req_valid && req_ready)
            solution_q.push_back(merge_congruence({req_start_req, req_residue, req_modulus}));
         if (rsp_valid && rsp_ready) begin
            if (solution_q.size() == 0) begin
               report_mismatch("unexpected result", rsp_combined_residue, '0);
            end else begin
               want = solution_q.pop_front();
               if (rsp_combined_residue !== want.residue)
                  report_mismatch("residue", rsp_combined_residue, want.residue);
               if (rsp_combined_modulus !== want.modulus)
                  report_mismatch("modulus", rsp_combined_modulus, want.modulus);
               if (rsp_status !== want.status)
                  report_mismatch("status", {62'd0, rsp_status}, {62'd0, want.status});
            end
         end
      end
   end

   // Watchdog: a stuck handshake ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cnt <= 0;
      else begin
         quiet_cnt <= quiet_cnt + 1;
         if (quiet_cnt >= WATCH_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      logic [63:0] x;
      logic [31:0] m;
      int          len;
      // directed: extremes, zero modulus, unreduced residue, non-coprime merge,
      // no solution, overflow, sticky failure
      add_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_item(1'b1, 32'd0, 32'd0);
      add_item(1'b0, 32'hFFFF_FFFF, 32'd0);
      add_item(1'b1, 32'd13, 32'd4);
      add_item(1'b0, 32'd3, 32'd6);
      add_item(1'b0, 32'd2, 32'd6);
      add_item(1'b0, 32'd5, 32'd7);
      add_item(1'b1, 32'd1, 32'd1);
      add_item(1'b1, 32'hFFFF_FFF0, 32'hFFFF_FFFB);
      add_item(1'b0, 32'h8000_0000, 32'hFFFF_FFFF);
      add_item(1'b0, 32'h1234_5678, 32'hFFFF_FFFD);
      add_item(1'b0, 32'd9, 32'd10);
      add_item(1'b1, 32'h5555_5555, 32'h8000_0000);
      add_item(1'b0, 32'hAAAA_AAAA, 32'h0000_0002);
      add_item(1'b0, 32'd0, 32'h0000_0003);
      // random: mostly consistent systems from a hidden solution
      while (pending_q.size() < 1715) begin
         x = {$urandom, $urandom};
         len = $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            m = pick_modulus();
            if ($urandom_range(0, 9) == 0)
               add_item(1'($urandom_range(0, 1)), $urandom, $urandom);
            else if ($urandom_range(0, 19) == 0) add_item(i == 0, $urandom, m);
            else if ($urandom_range(0, 39) == 0) add_item(i == 0, 32'(x % m), 32'd0);
            else add_item(i == 0, 32'((x % m) + m * $urandom_range(0, 3)), m);
         end
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait (pending_q.size() == 0 && !req_valid);
      wait (solution_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && solution_q.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

FILE: crt_general_merge_top.f
+incdir+rtl
rtl/cgm_pkg.sv
rtl/cgm_dpath.sv
rtl/cgm_ctrl.sv
rtl/crt_general_merge_top.sv
bench/crt_general_merge_top_tb.sv
